@@ design/flr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package flr_pkg;

  typedef enum logic [2:0] {
    CMD_LOG          = 3'd0,
    CMD_READ_AGE     = 3'd1,
    CMD_READ_LATEST  = 3'd2,
    CMD_ACK_LATEST   = 3'd3,
    CMD_ACK_ALL      = 3'd4,
    CMD_CLEAR        = 3'd5,
    CMD_CODE_COUNT   = 3'd6
  } cmd_e_t;

  localparam logic [1:0]  SEV_WARNING   = 2'd1;
  localparam logic [1:0]  SEV_CRITICAL  = 2'd2;
  localparam logic [15:0] THRESH_RESET  = 16'd3;

  // one log entry without its cleared flag, code in the lowest bits
  typedef struct packed {
    logic [7:0]  state;
    logic [31:0] time_ms;
    logic [31:0] limit;
    logic [31:0] measured;
    logic [1:0]  severity;
    logic [7:0]  code;
  } entry_t;

  typedef struct packed {
    logic        rd;
    logic        wr_ent;
    logic        wr_flag;
    logic        flag;
    logic [7:0]  addr;
    entry_t      ent;
  } log_req_t;

  typedef struct packed {
    logic        rd;
    logic        wr;
    logic        clr;
    logic [7:0]  addr;
    logic [15:0] data;
  } cnt_req_t;

endpackage

`default_nettype wire

@@ design/flr_log_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module flr_log_ram #(
  parameter int LOG_DEPTH = 16
) (
  input  wire                logic clk,
  input  wire  flr_pkg::log_req_t  req,
  output flr_pkg::entry_t          rd_ent,
  output logic                     rd_flag
);

  localparam int AW = $clog2(LOG_DEPTH);

  flr_pkg::entry_t ent_mem [LOG_DEPTH];
  logic            flag_mem [LOG_DEPTH];
  logic [AW-1:0]   addr;

  assign addr = req.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.wr_ent) begin
      ent_mem[addr] <= req.ent;
    end
    if (req.wr_flag) begin
      flag_mem[addr] <= req.flag;
    end
    if (req.rd) begin
      rd_ent  <= ent_mem[addr];
      rd_flag <= flag_mem[addr];
    end
  end

endmodule

`default_nettype wire

@@ design/flr_cnt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module flr_cnt_ram #(
  parameter int CODE_SPACE = 160
) (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire  flr_pkg::cnt_req_t  req,
  output logic [15:0]              rd_data
);

  localparam int CW = (CODE_SPACE > 1) ? $clog2(CODE_SPACE) : 1;

  logic [15:0]           mem [CODE_SPACE];
  logic [CODE_SPACE-1:0] valid_r;
  logic [15:0]           rd_q_r;
  logic                  rd_v_r;
  logic [CW-1:0]         addr;

  assign addr    = req.addr[CW-1:0];
  assign rd_data = rd_v_r ? rd_q_r : 16'd0;

  // an entry that is not valid reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.clr) begin
      valid_r <= '0;
    end else if (req.wr) begin
      valid_r[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[addr] <= req.data;
    end
    if (req.rd) begin
      rd_q_r <= mem[addr];
      rd_v_r <= valid_r[addr];
    end
  end

endmodule

`default_nettype wire

@@ design/fault_log_ring_with_escalation.sv @@
// An accepted word passes the address, execute and done states, and its result
// word is registered on out_tvalid once the output is free. Ack all adds a sweep
// that sets the cleared flag of each filled log entry. The sequencer and the
// single-port log and counter memories take no new word until the last is loaded.
// Reset: synchronous, active low; log empty, totals zero, threshold 3,
// per-code counters read zero at once (valid bits), no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module fault_log_ring_with_escalation #(
  parameter int LOG_DEPTH  = 16,
  parameter int CODE_SPACE = 160
) (
  input  wire  logic         clk,
  input  wire  logic         rst_n,
  input  wire  logic         in_tvalid,
  output logic               in_tready,
  // fault_code, severity_in, measured_bits, limit_bits, time_ms, prior_state, age_index
  input  wire  logic [119:0] in_tdata,
  // command
  input  wire  logic [2:0]   in_tuser,
  output logic               out_tvalid,
  input  wire  logic         out_tready,
  // entry_code, entry_severity, entry_measured, entry_limit, entry_time, entry_state,
  // entry_cleared, code_count, logged_total, active_faults, log_fill
  output logic [175:0]       out_tdata,
  // status
  output logic [0:0]         out_tuser,
  input  wire  logic         cfg_valid,
  output logic               cfg_ready,
  input  wire  logic [15:0]  cfg_data
);

  localparam int AW   = $clog2(LOG_DEPTH);
  localparam int FW   = $clog2(LOG_DEPTH + 1);
  localparam int CMPW = (FW > 4) ? FW : 4;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ADDR  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_SWEEP = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic            status;
    logic            cleared;
    logic [15:0]     count;
    flr_pkg::entry_t ent;
  } res_t;

  state_t            state_r, state_nxt;
  flr_pkg::cmd_e_t   cmd_r;
  flr_pkg::entry_t   item_r;
  logic [3:0]        age_r;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [FW-1:0]     active_r, active_nxt;
  logic [31:0]       total_r, total_nxt;
  logic [15:0]       thr_r;
  logic [AW-1:0]     idx_r, idx_nxt;
  res_t              res_r, res_nxt;
  logic              out_valid_r;
  logic [175:0]      out_data_r;
  logic              out_status_r;

  flr_pkg::log_req_t log_req;
  flr_pkg::cnt_req_t cnt_req;
  flr_pkg::entry_t   log_rd_ent;
  logic              log_rd_flag;
  logic [15:0]       cnt_rd;

  logic [AW-1:0]     newest;
  logic [AW:0]       phys_sum;
  logic [AW-1:0]     phys;
  logic              not_full;
  logic              empty;
  logic              age_bad;
  logic              code_in;
  logic [15:0]       cnt_inc;
  logic              escalate;
  logic              in_acc;
  logic              out_load;

  flr_log_ram #(.LOG_DEPTH(LOG_DEPTH)) u_log_ram (
    .clk     (clk),
    .req     (log_req),
    .rd_ent  (log_rd_ent),
    .rd_flag (log_rd_flag)
  );

  flr_cnt_ram #(.CODE_SPACE(CODE_SPACE)) u_cnt_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (cnt_req),
    .rd_data (cnt_rd)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);

  assign newest   = (wp_r == '0) ? AW'(LOG_DEPTH - 1) : wp_r - 1'b1;
  assign phys_sum = {1'b0, wp_r} + (AW + 1)'(age_r);
  assign phys     = (phys_sum >= (AW + 1)'(LOG_DEPTH)) ?
                    AW'(phys_sum - (AW + 1)'(LOG_DEPTH)) : phys_sum[AW-1:0];
  assign not_full = fill_r < FW'(LOG_DEPTH);
  assign empty    = (fill_r == '0);
  assign age_bad  = CMPW'(age_r) >= CMPW'(fill_r);
  assign code_in  = 9'(item_r.code) < 9'(CODE_SPACE);

  // shared increment and threshold compare
  assign cnt_inc  = cnt_rd + 16'd1;
  assign escalate = code_in && (item_r.severity == flr_pkg::SEV_WARNING) &&
                    (cnt_inc >= thr_r);

  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    fill_nxt   = fill_r;
    active_nxt = active_r;
    total_nxt  = total_r;
    idx_nxt    = idx_r;
    res_nxt    = res_r;
    log_req    = '0;
    cnt_req    = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        log_req.rd   = 1'b1;
        cnt_req.rd   = 1'b1;
        cnt_req.addr = item_r.code;
        case (cmd_r)
          flr_pkg::CMD_READ_AGE: log_req.addr = 8'(not_full ? age_r : 4'(phys));
          flr_pkg::CMD_READ_LATEST,
          flr_pkg::CMD_ACK_LATEST: log_req.addr = 8'(newest);
          default: log_req.addr = 8'(wp_r);
        endcase
        if (cmd_r == flr_pkg::CMD_READ_AGE && !not_full) begin
          log_req.addr = 8'(phys);
        end
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        res_nxt   = '0;
        state_nxt = S_DONE;
        case (cmd_r)
          flr_pkg::CMD_LOG: begin
            if (code_in) begin
              cnt_req.wr   = 1'b1;
              cnt_req.addr = item_r.code;
              cnt_req.data = cnt_inc;
              res_nxt.count = cnt_inc;
            end
            log_req.wr_ent  = 1'b1;
            log_req.wr_flag = 1'b1;
            log_req.flag    = 1'b0;
            log_req.addr    = 8'(wp_r);
            log_req.ent     = item_r;
            if (escalate) begin
              log_req.ent.severity = flr_pkg::SEV_CRITICAL;
            end
            wp_nxt = (wp_r == AW'(LOG_DEPTH - 1)) ? '0 : wp_r + 1'b1;
            if (not_full) begin
              fill_nxt   = fill_r + 1'b1;
              active_nxt = active_r + 1'b1;
            end else if (log_rd_flag) begin
              active_nxt = active_r + 1'b1;
            end
            total_nxt = total_r + 32'd1;
          end
          flr_pkg::CMD_READ_AGE: begin
            if (age_bad) begin
              res_nxt.status = 1'b1;
            end else begin
              res_nxt.ent     = log_rd_ent;
              res_nxt.cleared = log_rd_flag;
            end
          end
          flr_pkg::CMD_READ_LATEST: begin
            if (empty) begin
              res_nxt.status = 1'b1;
            end else begin
              res_nxt.ent     = log_rd_ent;
              res_nxt.cleared = log_rd_flag;
            end
          end
          flr_pkg::CMD_ACK_LATEST: begin
            if (empty) begin
              res_nxt.status = 1'b1;
            end else begin
              log_req.wr_flag = 1'b1;
              log_req.flag    = 1'b1;
              log_req.addr    = 8'(newest);
              if (!log_rd_flag) begin
                active_nxt = active_r - 1'b1;
              end
            end
          end
          flr_pkg::CMD_ACK_ALL: begin
            active_nxt = '0;
            idx_nxt    = '0;
            if (!empty) begin
              state_nxt = S_SWEEP;
            end
          end
          flr_pkg::CMD_CLEAR: begin
            cnt_req.clr = 1'b1;
            wp_nxt      = '0;
            fill_nxt    = '0;
            active_nxt  = '0;
            total_nxt   = '0;
          end
          flr_pkg::CMD_CODE_COUNT: begin
            if (code_in) begin
              res_nxt.count = cnt_rd;
            end
          end
          default: begin
          end
        endcase
      end
      S_SWEEP: begin
        log_req.wr_flag = 1'b1;
        log_req.flag    = 1'b1;
        log_req.addr    = 8'(idx_r);
        idx_nxt         = idx_r + 1'b1;
        if (FW'(idx_r) + FW'(1) == fill_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      active_r    <= '0;
      total_r     <= '0;
      thr_r       <= flr_pkg::THRESH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      fill_r   <= fill_nxt;
      active_r <= active_nxt;
      total_r  <= total_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= flr_pkg::cmd_e_t'(in_tuser);
      item_r <= flr_pkg::entry_t'(in_tdata[113:0]);
      age_r  <= in_tdata[117:114];
    end
    idx_r <= idx_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_status_r <= res_r.status;
      out_data_r   <= {3'b000, 5'(fill_r), 5'(active_r), total_r, res_r.count,
                       res_r.cleared, res_r.ent};
    end
  end

endmodule

`default_nettype wire

@@ design/flr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module flr_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [175:0] out_tdata,
  input wire logic [0:0]   out_tuser
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed or dropped");

  // busy right after an accepted word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a word is in work");

  // error status carries no entry
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[114:0] == 115'd0)
    else $error("error result with entry fields set");

  // active never above fill
  a_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[167:163] <= out_tdata[172:168])
    else $error("active count above log fill");

endmodule

bind fault_log_ring_with_escalation flr_checker u_flr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

@@ tb/fault_log_ring_with_escalation_test.sv @@
`timescale 1ns / 1ps

module fault_log_ring_with_escalation_test;

  localparam int RING_DEPTH = 16;
  localparam int CODE_SPACE = 160;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 285;
  localparam int QUIET_LOGS = 20;
  localparam int SETTLE_CYCLES = 24;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam logic [1:0] SEV_INFO = 2'd0;
  localparam logic [1:0] SEV_CATASTROPHIC = 2'd3;

  localparam int PAY_RANDOM = 0;
  localparam int PAY_ZERO = 1;
  localparam int PAY_ONES = 2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  code;
    logic [1:0]  sev;
    logic [31:0] measured;
    logic [31:0] limit;
    logic [31:0] stamp;
    logic [7:0]  prior;
    logic [3:0]  age;
  } fault_cmd_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  code;
    logic [1:0]  sev;
    logic [31:0] measured;
    logic [31:0] limit;
    logic [31:0] stamp;
    logic [7:0]  prior;
    logic        cleared;
    logic [15:0] count;
    logic [31:0] total;
    logic [4:0]  active;
    logic [4:0]  fill;
  } fault_report_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [175:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;

  fault_log_ring_with_escalation #(
    .LOG_DEPTH (RING_DEPTH),
    .CODE_SPACE(CODE_SPACE)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  fault_cmd_t    pending_words[$];
  fault_report_t expected_reports[$];
  fault_cmd_t    in_flight = '0;
  int            in_gap = 0;
  int            out_stall = 0;
  bit            quiet = 1'b0;
  int            errors = 0;
  int            words_sent = 0;
  int            results_seen = 0;
  int            settings_used = 1;
  int unsigned   cycle_count = 0;

  logic [7:0]  ring_code[RING_DEPTH];
  logic [1:0]  ring_sev[RING_DEPTH];
  logic [31:0] ring_measured[RING_DEPTH];
  logic [31:0] ring_limit[RING_DEPTH];
  logic [31:0] ring_stamp[RING_DEPTH];
  logic [7:0]  ring_prior[RING_DEPTH];
  logic        ring_cleared[RING_DEPTH];
  logic [15:0] code_hits[CODE_SPACE];
  logic [3:0]  ring_wr = '0;
  logic [4:0]  ring_fill = '0;
  logic [31:0] fault_total = '0;
  logic [15:0] esc_limit = flr_pkg::THRESH_RESET;

  initial begin
    for (int i = 0; i < CODE_SPACE; i++) code_hits[i] = '0;
    for (int i = 0; i < RING_DEPTH; i++) ring_cleared[i] = 1'b0;
  end

  function automatic fault_report_t with_entry(fault_report_t r, logic [3:0] slot);
    r.code = ring_code[slot];
    r.sev = ring_sev[slot];
    r.measured = ring_measured[slot];
    r.limit = ring_limit[slot];
    r.stamp = ring_stamp[slot];
    r.prior = ring_prior[slot];
    r.cleared = ring_cleared[slot];
    return r;
  endfunction

  function automatic fault_report_t apply_fault_command(fault_cmd_t c);
    fault_report_t r;
    logic [3:0]    newest;
    logic [3:0]    slot;
    logic [1:0]    sev;
    logic [4:0]    active;
    r = '0;
    sev = c.sev;
    newest = ring_wr - 4'd1;
    case (c.cmd)
      flr_pkg::CMD_LOG: begin
        if (c.code < CODE_SPACE) begin
          code_hits[c.code] = code_hits[c.code] + 16'd1;
          if (sev == flr_pkg::SEV_WARNING && code_hits[c.code] >= esc_limit)
            sev = flr_pkg::SEV_CRITICAL;
          r.count = code_hits[c.code];
        end
        ring_code[ring_wr] = c.code;
        ring_sev[ring_wr] = sev;
        ring_measured[ring_wr] = c.measured;
        ring_limit[ring_wr] = c.limit;
        ring_stamp[ring_wr] = c.stamp;
        ring_prior[ring_wr] = c.prior;
        ring_cleared[ring_wr] = 1'b0;
        ring_wr = ring_wr + 4'd1;
        if (ring_fill < RING_DEPTH) ring_fill = ring_fill + 5'd1;
        fault_total = fault_total + 32'd1;
      end
      flr_pkg::CMD_READ_AGE: begin
        if ({1'b0, c.age} >= ring_fill) begin
          r.status = 1'b1;
        end else begin
          slot = (ring_fill < RING_DEPTH) ? c.age : ring_wr + c.age;
          r = with_entry(r, slot);
        end
      end
      flr_pkg::CMD_READ_LATEST: begin
        if (ring_fill == 0) r.status = 1'b1;
        else r = with_entry(r, newest);
      end
      flr_pkg::CMD_ACK_LATEST: begin
        if (ring_fill == 0) r.status = 1'b1;
        else ring_cleared[newest] = 1'b1;
      end
      flr_pkg::CMD_ACK_ALL: begin
        for (int i = 0; i < ring_fill; i++) ring_cleared[i] = 1'b1;
      end
      flr_pkg::CMD_CLEAR: begin
        for (int i = 0; i < CODE_SPACE; i++) code_hits[i] = '0;
        for (int i = 0; i < RING_DEPTH; i++) ring_cleared[i] = 1'b0;
        ring_wr = '0;
        ring_fill = '0;
        fault_total = '0;
      end
      flr_pkg::CMD_CODE_COUNT: begin
        if (c.code < CODE_SPACE) r.count = code_hits[c.code];
      end
      default: begin
      end
    endcase
    active = '0;
    for (int i = 0; i < ring_fill; i++) if (!ring_cleared[i]) active = active + 5'd1;
    r.total = fault_total;
    r.active = active;
    r.fill = ring_fill;
    return r;
  endfunction

  function automatic fault_cmd_t fault_word(logic [2:0] cmd, logic [7:0] code,
                                            logic [1:0] sev, logic [3:0] age, int pattern);
    fault_cmd_t w;
    w.cmd = cmd;
    w.code = code;
    w.sev = sev;
    w.age = age;
    case (pattern)
      PAY_ZERO: begin
        w.measured = '0;
        w.limit = '0;
        w.stamp = '0;
        w.prior = '0;
      end
      PAY_ONES: begin
        w.measured = '1;
        w.limit = '1;
        w.stamp = '1;
        w.prior = '1;
      end
      default: begin
        w.measured = $urandom;
        w.limit = $urandom;
        w.stamp = $urandom;
        w.prior = 8'($urandom_range(0, 255));
      end
    endcase
    return w;
  endfunction

  task automatic queue_word(logic [2:0] cmd, logic [7:0] code, logic [1:0] sev,
                            logic [3:0] age, int pattern);
    pending_words.push_back(fault_word(cmd, code, sev, age, pattern));
  endtask

  task automatic queue_random_words(int count);
    int         r;
    logic [2:0] cmd;
    logic [7:0] code;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 42) cmd = flr_pkg::CMD_LOG;
      else if (r < 60) cmd = flr_pkg::CMD_READ_AGE;
      else if (r < 70) cmd = flr_pkg::CMD_READ_LATEST;
      else if (r < 78) cmd = flr_pkg::CMD_ACK_LATEST;
      else if (r < 83) cmd = flr_pkg::CMD_ACK_ALL;
      else if (r < 84) cmd = flr_pkg::CMD_CLEAR;
      else if (r < 97) cmd = flr_pkg::CMD_CODE_COUNT;
      else cmd = CMD_UNUSED;
      r = $urandom_range(0, 99);
      if (r < 70) code = 8'($urandom_range(0, 7));
      else if (r < 85) code = 8'($urandom_range(0, CODE_SPACE - 1));
      else code = 8'($urandom_range(0, 255));
      queue_word(cmd, code, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                 PAY_RANDOM);
    end
  endtask

  task automatic drain;
    while (pending_words.size() != 0 || in_tvalid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    esc_limit = value;
    settings_used++;
  endtask

  // drive input words
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_words.size() > 0) begin
        in_flight <= pending_words[0];
        in_tvalid <= 1'b1;
        in_tuser <= pending_words[0].cmd;
        in_tdata <= {2'b0, pending_words[0].age, pending_words[0].prior,
                     pending_words[0].stamp, pending_words[0].limit,
                     pending_words[0].measured, pending_words[0].sev, pending_words[0].code};
        void'(pending_words.pop_front());
        if (!quiet && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 4);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // stall the result side
  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      out_stall <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expected_reports.push_back(apply_fault_command(in_flight));
      words_sent++;
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    fault_report_t want;
    fault_report_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser[0];
      got.code = out_tdata[7:0];
      got.sev = out_tdata[9:8];
      got.measured = out_tdata[41:10];
      got.limit = out_tdata[73:42];
      got.stamp = out_tdata[105:74];
      got.prior = out_tdata[113:106];
      got.cleared = out_tdata[114];
      got.count = out_tdata[130:115];
      got.total = out_tdata[162:131];
      got.active = out_tdata[167:163];
      got.fill = out_tdata[172:168];
      results_seen++;
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, actual %0h", $time, out_tdata);
      end else begin
        want = expected_reports.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("entry_code", 32'(want.code), 32'(got.code));
        check_field("entry_severity", 32'(want.sev), 32'(got.sev));
        check_field("entry_measured", want.measured, got.measured);
        check_field("entry_limit", want.limit, got.limit);
        check_field("entry_time", want.stamp, got.stamp);
        check_field("entry_state", 32'(want.prior), 32'(got.prior));
        check_field("entry_cleared", 32'(want.cleared), 32'(got.cleared));
        check_field("code_count", 32'(want.count), 32'(got.count));
        check_field("logged_total", want.total, got.total);
        check_field("active_faults", 32'(want.active), 32'(got.active));
        check_field("log_fill", 32'(want.fill), 32'(got.fill));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] phase_limits[5];
    phase_limits[0] = 16'd1;
    phase_limits[1] = 16'hFFFF;
    phase_limits[2] = 16'd0;
    phase_limits[3] = 16'($urandom_range(2, 12));
    phase_limits[4] = flr_pkg::THRESH_RESET;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    queue_word(flr_pkg::CMD_READ_LATEST, 8'd0, SEV_INFO, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_READ_AGE, 8'd0, SEV_INFO, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_ACK_LATEST, 8'd0, SEV_INFO, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_ACK_ALL, 8'd0, SEV_INFO, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_CODE_COUNT, 8'd0, SEV_INFO, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_CODE_COUNT, 8'd255, SEV_INFO, 4'd0, PAY_RANDOM);
    queue_word(CMD_UNUSED, 8'd255, SEV_CATASTROPHIC, 4'd15, PAY_ONES);
    queue_word(flr_pkg::CMD_LOG, 8'd0, flr_pkg::SEV_WARNING, 4'd0, PAY_ZERO);
    queue_word(flr_pkg::CMD_LOG, 8'd0, flr_pkg::SEV_WARNING, 4'd15, PAY_ONES);
    queue_word(flr_pkg::CMD_LOG, 8'd0, flr_pkg::SEV_WARNING, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_LOG, 8'd159, SEV_CATASTROPHIC, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_LOG, 8'd160, flr_pkg::SEV_WARNING, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_LOG, 8'd255, SEV_INFO, 4'd0, PAY_ONES);
    queue_word(flr_pkg::CMD_LOG, 8'd1, flr_pkg::SEV_CRITICAL, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_READ_AGE, 8'd0, SEV_INFO, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_READ_AGE, 8'd0, SEV_INFO, 4'd6, PAY_RANDOM);
    queue_word(flr_pkg::CMD_READ_AGE, 8'd0, SEV_INFO, 4'd7, PAY_RANDOM);
    queue_word(flr_pkg::CMD_READ_AGE, 8'd0, SEV_INFO, 4'd15, PAY_RANDOM);
    queue_word(flr_pkg::CMD_READ_LATEST, 8'd0, SEV_INFO, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_ACK_LATEST, 8'd0, SEV_INFO, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_READ_LATEST, 8'd0, SEV_INFO, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_CODE_COUNT, 8'd0, SEV_INFO, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_CODE_COUNT, 8'd160, SEV_INFO, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_ACK_ALL, 8'd0, SEV_INFO, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_READ_AGE, 8'd0, SEV_INFO, 4'd2, PAY_RANDOM);
    queue_word(flr_pkg::CMD_CLEAR, 8'd0, SEV_INFO, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_READ_LATEST, 8'd0, SEV_INFO, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_CODE_COUNT, 8'd0, SEV_INFO, 4'd0, PAY_RANDOM);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_threshold(phase_limits[p]);
      queue_random_words(PHASE_WORDS);
      drain();
    end

    // log one code around the ring back to back, crossing the threshold
    quiet = 1'b1;
    write_threshold(16'd12);
    queue_word(flr_pkg::CMD_CLEAR, 8'd0, SEV_INFO, 4'd0, PAY_RANDOM);
    for (int n = 0; n < QUIET_LOGS; n++)
      queue_word(flr_pkg::CMD_LOG, 8'd9, flr_pkg::SEV_WARNING, 4'($urandom_range(0, 15)),
                 PAY_RANDOM);
    queue_word(flr_pkg::CMD_CODE_COUNT, 8'd9, SEV_INFO, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_READ_LATEST, 8'd0, SEV_INFO, 4'd0, PAY_RANDOM);
    queue_word(flr_pkg::CMD_READ_AGE, 8'd0, SEV_INFO, 4'd0, PAY_RANDOM);
    drain();

    $display("Sent %0d command words under %0d threshold settings, ending with a wrapped ring.",
             words_sent, settings_used);
    $display("Checked %0d result words, %0d mismatching fields.", results_seen, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
